// File: src/tlvd_pkg.sv
package tlvd_pkg;

   // Header layout: 4 type bytes, then 4 length bytes, both big-endian
   localparam int unsigned HEADER_BYTES = 8;
   localparam int unsigned HDR_CNT_W    = $clog2(HEADER_BYTES);

   // Reset value of the maximum value length register
   localparam logic [31:0] MAX_LEN_RESET = 32'd65536;

   // Request commands
   localparam logic CMD_BYTE  = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   // Result event kinds
   localparam logic [1:0] EV_VALUE = 2'd0;
   localparam logic [1:0] EV_EMPTY = 2'd1;
   localparam logic [1:0] EV_ERROR = 2'd2;

   typedef struct packed {
      logic       command;
      logic [7:0] stream_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  event_kind;
      logic [31:0] frame_type;
      logic [7:0]  value_byte;
      logic [31:0] packet_length;
      logic        last_of_packet;
   } rsp_type;

   // Handshake between the parser and the result register
   typedef struct packed {
      logic take;   // parser consumes the held beat
      logic push;   // beat produces a result
   } step_type;

endpackage

// File: src/tlvd_in_reg.sv
module tlvd_in_reg
   import tlvd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   input  logic    take,
   output logic    held_valid,
   output req_type held_data
);

   logic    valid_ff, valid_in;
   req_type data_ff;
   logic    load;

   // Refill whenever empty or the held beat is consumed this cycle
   assign load      = !valid_ff || take;
   assign req_stall = !load;
   assign valid_in  = load ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && req_valid) begin
         data_ff <= req_data;
      end
   end

   assign held_valid = valid_ff;
   assign held_data  = data_ff;

endmodule

// File: src/tlvd_parser.sv
module tlvd_parser
   import tlvd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        held_valid,
   input  req_type     held_data,
   input  logic        out_free,
   input  logic [31:0] max_len,
   output step_type    step,
   output rsp_type     result
);

   logic                 vphase_ff, vphase_in;
   logic [HDR_CNT_W-1:0] hcnt_ff, hcnt_in;
   logic [31:0]          type_ff, type_in;
   logic [31:0]          len_ff, len_in;
   logic [31:0]          remain_ff, remain_in;
   logic                 produce;
   logic                 last;
   logic                 hdr_done;

   // Next state and result for the held beat
   always_comb begin
      vphase_in = vphase_ff;
      hcnt_in   = hcnt_ff;
      type_in   = type_ff;
      len_in    = len_ff;
      remain_in = remain_ff;
      produce   = 1'b0;
      last      = (remain_ff <= 32'd1);
      hdr_done  = 1'b0;
      result    = '0;

      if (held_data.command == CMD_CLEAR) begin
         vphase_in = 1'b0;
         hcnt_in   = '0;
         type_in   = '0;
         len_in    = '0;
         remain_in = '0;
      end else if (vphase_ff) begin
         produce               = 1'b1;
         result.event_kind     = EV_VALUE;
         result.value_byte     = held_data.stream_byte;
         result.last_of_packet = last;
         if (last) begin
            remain_in = '0;
            vphase_in = 1'b0;
         end else begin
            remain_in = remain_ff - 32'd1;
         end
      end else begin
         // type bytes in the first half of the header, length in the second
         if (!hcnt_ff[HDR_CNT_W-1]) begin
            type_in = {type_ff[23:0], held_data.stream_byte};
         end else begin
            len_in = {len_ff[23:0], held_data.stream_byte};
         end
         hcnt_in  = hcnt_ff + 1'b1;
         hdr_done = (hcnt_ff == HDR_CNT_W'(HEADER_BYTES - 1));
         if (hdr_done) begin
            if (len_in > max_len) begin
               produce               = 1'b1;
               result.event_kind     = EV_ERROR;
               result.last_of_packet = 1'b1;
            end else if (len_in == 32'd0) begin
               produce               = 1'b1;
               result.event_kind     = EV_EMPTY;
               result.last_of_packet = 1'b1;
            end else begin
               vphase_in = 1'b1;
               remain_in = len_in;
            end
         end
      end
      result.frame_type    = type_in;
      result.packet_length = len_in;
   end

   // Beat moves on unless its result would hit a full output register
   assign step.take = held_valid && (!produce || out_free);
   assign step.push = step.take && produce;

   always_ff @(posedge clock) begin
      if (reset) begin
         vphase_ff <= 1'b0;
         hcnt_ff   <= '0;
         type_ff   <= '0;
         len_ff    <= '0;
         remain_ff <= '0;
      end else if (step.take) begin
         vphase_ff <= vphase_in;
         hcnt_ff   <= hcnt_in;
         type_ff   <= type_in;
         len_ff    <= len_in;
         remain_ff <= remain_in;
      end
   end

endmodule

// File: src/tlvd_out_reg.sv
module tlvd_out_reg
   import tlvd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  step_type step,
   input  rsp_type  result,
   output logic     out_free,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   // Free when empty or the current beat leaves this cycle
   assign out_free = !valid_ff || !rsp_stall;
   assign valid_in = out_free ? step.push : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step.push) begin
         data_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// File: src/tlv_stream_deframer_core.sv
// Channel | Dir | Handshake          | Beat
// req     | in  | req_valid/stall    | req_type: command, stream_byte
// rsp     | out | rsp_valid/stall    | rsp_type: event, type, byte, length, last
// csr     | in  | csr_valid/ready    | max value length, 32 bits
//
// One byte per clock sustained while rsp is not stalled; a beat is held in the
// input register and its result is registered into the output register.
// The per-byte work is one header shift or one remaining-count decrement and
// a 32-bit length compare, all combinational between the two registers.
// Reset is synchronous; it returns to header hunting and sets the maximum
// length to 65536. Stalls on rsp hold the result register and back up
// into req only when a beat that makes a result finds it full.
module tlv_stream_deframer_core
   import tlvd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);

   logic        held_valid;
   req_type     held_data;
   step_type    step;
   rsp_type     result;
   logic        out_free;
   logic [31:0] max_len_ff;

   // Maximum value length register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
      end else if (csr_valid && csr_ready) begin
         max_len_ff <= csr_data;
      end
   end

   tlvd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .take       (step.take),
      .held_valid (held_valid),
      .held_data  (held_data)
   );

   tlvd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .held_valid (held_valid),
      .held_data  (held_data),
      .out_free   (out_free),
      .max_len    (max_len_ff),
      .step       (step),
      .result     (result)
   );

   tlvd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .result    (result),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: src/tlvd_checker.sv
module tlvd_checker
   import tlvd_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // A stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed under stall");

   // No result can come out in the cycle after reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   // Empty and error results close the packet and carry no byte
   a_rsp_close: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.event_kind == EV_EMPTY || rsp_data.event_kind == EV_ERROR)
      |-> rsp_data.last_of_packet && rsp_data.value_byte == 8'd0)
      else $error("empty or error result malformed");

   // Only defined event kinds appear
   a_rsp_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.event_kind == EV_VALUE || rsp_data.event_kind == EV_EMPTY
                     || rsp_data.event_kind == EV_ERROR))
      else $error("undefined event kind");

   // Input backs up only when the result side is stalled
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req stalled without rsp backpressure");

endmodule

bind tlv_stream_deframer_core tlvd_checker u_tlvd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
